// ===== rtl/itaf_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// itaf_pkg
// shared types, codes and helpers of the integer-to-ascii formatter
// ---------------------------------------------------------------------------
package itaf_pkg;

  // request format codes
  typedef enum logic [1:0] {
    REQ_SDEC32 = 2'd0,
    REQ_UDEC32 = 2'd1,
    REQ_HEX32  = 2'd2,
    REQ_HEX64  = 2'd3
  } req_type_t;

  localparam int VALUE_W      = 64;
  localparam int WORD_W       = 32;
  localparam int CHAR_W       = 8;
  localparam int COUNT_W      = 32;
  localparam int NIBBLES      = VALUE_W / 4;
  localparam int BCD_DIGITS   = 10;
  localparam int QUEUE_DEPTH  = 2;

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2d;
  localparam logic [CHAR_W-1:0] CHAR_UA    = 8'h41;
  localparam logic [CHAR_W-1:0] CHAR_LA    = 8'h61;

  // classified word handed from front to back
  typedef struct packed {
    logic               dec;
    logic               upper;
    logic               neg;
    logic [VALUE_W-1:0] mag;
  } cls_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_CONV,
    BK_FIND,
    BK_EMIT
  } bk_state_t;

  function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] nib,
                                                   input logic upper);
    logic [CHAR_W-1:0] base;
    base = upper ? CHAR_UA : CHAR_LA;
    if (nib < 4'd10) begin
      digit_char = CHAR_ZERO + {4'd0, nib};
    end else begin
      digit_char = base + {4'd0, nib} - 8'd10;
    end
  endfunction

endpackage
`default_nettype wire

// ===== rtl/itaf_front.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// itaf_front
// accepts request words, picks sign and magnitude, holds one classified word
// ---------------------------------------------------------------------------
module itaf_front import itaf_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [1:0]         in_req_type,
  input  wire logic               in_upper_case,
  input  wire logic [VALUE_W-1:0] in_value,
  output logic                    push_valid,
  output cls_t                    push_data,
  input  wire logic               push_full
);

  logic f_valid_r, f_valid_nxt;
  cls_t f_data_r, f_data_nxt;
  logic accept, push;
  logic [WORD_W-1:0] low, neg_low;

  assign in_stall   = f_valid_r && push_full;
  assign accept     = in_valid && !in_stall;
  assign push       = f_valid_r && !push_full;
  assign push_valid = f_valid_r;
  assign push_data  = f_data_r;

  assign low     = in_value[WORD_W-1:0];
  assign neg_low = ~low + 1'b1;

  always_comb begin
    f_data_nxt       = f_data_r;
    f_data_nxt.upper = in_upper_case;
    f_data_nxt.neg   = 1'b0;
    f_data_nxt.dec   = 1'b0;
    f_data_nxt.mag   = {{(VALUE_W-WORD_W){1'b0}}, low};
    unique case (req_type_t'(in_req_type))
      REQ_SDEC32: begin
        f_data_nxt.dec = 1'b1;
        f_data_nxt.neg = low[WORD_W-1];
        if (low[WORD_W-1]) begin
          f_data_nxt.mag = {{(VALUE_W-WORD_W){1'b0}}, neg_low};
        end
      end
      REQ_UDEC32: begin
        f_data_nxt.dec = 1'b1;
      end
      REQ_HEX32: begin
      end
      REQ_HEX64: begin
        f_data_nxt.mag = in_value;
      end
      default: begin
      end
    endcase
    if (accept) begin
      f_valid_nxt = 1'b1;
    end else if (push) begin
      f_valid_nxt = 1'b0;
    end else begin
      f_valid_nxt = f_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_valid_r <= 1'b0;
    end else begin
      f_valid_r <= f_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f_data_r <= f_data_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/itaf_queue.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// itaf_queue
// short first-in first-out queue of classified words
// ---------------------------------------------------------------------------
module itaf_queue import itaf_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push_valid,
  input  wire cls_t push_data,
  output logic      push_full,
  output logic      pop_valid,
  output cls_t      pop_data,
  input  wire logic pop
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  cls_t mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic do_push, do_pop;

  assign push_full = (cnt_r == FULL_CNT);
  assign pop_valid = (cnt_r != '0);
  assign pop_data  = mem_r[rd_ptr_r];
  assign do_push   = push_valid && !push_full;
  assign do_pop    = pop && pop_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/itaf_back.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// itaf_back
// decimal conversion, leading-zero search and character output
// ---------------------------------------------------------------------------
module itaf_back import itaf_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                pop_valid,
  input  wire cls_t                pop_data,
  output logic                     pop,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [CHAR_W-1:0]        out_char,
  output logic                     out_last,
  output logic [COUNT_W-1:0]       out_total_count
);

  localparam int BCD_W    = 4 * BCD_DIGITS;
  localparam int STEPS    = WORD_W / 2;
  localparam int STEP_W   = $clog2(STEPS);
  localparam int POS_W    = $clog2(NIBBLES);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(STEPS - 1);

  // one shift-and-add-3 step of the binary to bcd conversion
  function automatic logic [BCD_W-1:0] dd_step(input logic [BCD_W-1:0] bcd,
                                               input logic bin_bit);
    logic [BCD_W-1:0] adj;
    adj = bcd;
    for (int d = 0; d < BCD_DIGITS; d++) begin
      if (bcd[4*d +: 4] >= 4'd5) begin
        adj[4*d +: 4] = bcd[4*d +: 4] + 4'd3;
      end
    end
    dd_step = {adj[BCD_W-2:0], bin_bit};
  endfunction

  bk_state_t         state_r, state_nxt;
  logic [WORD_W-1:0] bin_r, bin_nxt;
  logic [BCD_W-1:0]  bcd_r, bcd_nxt, bcd_one, bcd_two;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [VALUE_W-1:0] dig_r, dig_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt, lead_pos;
  logic              upper_r, upper_nxt;
  logic              sign_r, sign_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0] out_char_r, out_char_nxt;
  logic              out_last_r, out_last_nxt;
  logic [COUNT_W-1:0] total_r, total_nxt;
  logic              out_free;

  assign out_valid       = out_valid_r;
  assign out_char        = out_char_r;
  assign out_last        = out_last_r;
  assign out_total_count = total_r;
  assign out_free        = !out_valid_r || !out_stall;

  assign bcd_one = dd_step(bcd_r, bin_r[WORD_W-1]);
  assign bcd_two = dd_step(bcd_one, bin_r[WORD_W-2]);

  // highest nonzero digit, zero when the value is zero
  always_comb begin
    lead_pos = '0;
    for (int i = 0; i < NIBBLES; i++) begin
      if (dig_r[4*i +: 4] != 4'd0) begin
        lead_pos = POS_W'(i);
      end
    end
  end

  always_comb begin
    state_nxt     = state_r;
    bin_nxt       = bin_r;
    bcd_nxt       = bcd_r;
    step_nxt      = step_r;
    dig_nxt       = dig_r;
    pos_nxt       = pos_r;
    upper_nxt     = upper_r;
    sign_nxt      = sign_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    total_nxt     = total_r;
    pop           = 1'b0;
    unique case (state_r)
      BK_IDLE: begin
        if (pop_valid) begin
          pop       = 1'b1;
          upper_nxt = pop_data.upper;
          sign_nxt  = pop_data.neg;
          if (pop_data.dec) begin
            bin_nxt   = pop_data.mag[WORD_W-1:0];
            bcd_nxt   = '0;
            step_nxt  = '0;
            state_nxt = BK_CONV;
          end else begin
            dig_nxt   = pop_data.mag;
            state_nxt = BK_FIND;
          end
        end
      end
      BK_CONV: begin
        bcd_nxt  = bcd_two;
        bin_nxt  = {bin_r[WORD_W-3:0], 2'b00};
        step_nxt = step_r + 1'b1;
        if (step_r == LAST_STEP) begin
          dig_nxt   = {{(VALUE_W-BCD_W){1'b0}}, bcd_two};
          state_nxt = BK_FIND;
        end
      end
      BK_FIND: begin
        pos_nxt   = lead_pos;
        state_nxt = BK_EMIT;
      end
      BK_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          total_nxt     = total_r + 1'b1;
          if (sign_r) begin
            out_char_nxt = CHAR_MINUS;
            out_last_nxt = 1'b0;
            sign_nxt     = 1'b0;
          end else begin
            out_char_nxt = digit_char(dig_r[4*pos_r +: 4], upper_r);
            out_last_nxt = (pos_r == '0);
            if (pos_r == '0) begin
              state_nxt = BK_IDLE;
            end else begin
              pos_nxt = pos_r - 1'b1;
            end
          end
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      out_valid_r <= 1'b0;
      total_r     <= '0;
      sign_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      total_r     <= total_nxt;
      sign_r      <= sign_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bin_r      <= bin_nxt;
    bcd_r      <= bcd_nxt;
    step_r     <= step_nxt;
    dig_r      <= dig_nxt;
    pos_r      <= pos_nxt;
    upper_r    <= upper_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

endmodule
`default_nettype wire

// ===== rtl/integer_to_ascii_formatter.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// integer_to_ascii_formatter
// prints one number per request as ascii text, one character per word
// ---------------------------------------------------------------------------
// Each request word carries a number and a format (signed or unsigned 32-bit
// decimal, 32-bit or 64-bit hex, lower or upper case letters). The text leaves
// most significant digit first, without leading zeros, with a leading '-' for
// negative signed values; zero prints as a single '0'. out_last marks the
// final character of a number, and out_total_count gives the running number of
// characters sent so far including this one, wrapping at 32 bits. A hex
// request goes straight to the leading-zero search; a decimal request first
// passes the binary to bcd unit, which shifts in two bits per cycle. A
// two-entry queue sits between the request side and the converter, so up to
// three requests can be taken ahead of the one being printed.
// ---------------------------------------------------------------------------
module integer_to_ascii_formatter import itaf_pkg::*; #(
  parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  // request channel
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [1:0]          in_req_type,
  input  wire logic                in_upper_case,
  input  wire logic [VALUE_W-1:0]  in_value,
  // character channel
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [CHAR_W-1:0]        out_char,
  output logic                     out_last,
  output logic [COUNT_W-1:0]       out_total_count
);

  // classified words between front and queue, queue and back
  logic push_valid, push_full;
  cls_t push_data;
  logic pop_valid, pop;
  cls_t pop_data;

  // front: request register, sign and magnitude split
  itaf_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_req_type   (in_req_type),
    .in_upper_case (in_upper_case),
    .in_value      (in_value),
    .push_valid    (push_valid),
    .push_data     (push_data),
    .push_full     (push_full)
  );

  // decoupling queue
  itaf_queue #(
    .DEPTH (QUEUE_DEPTH_P)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_data  (push_data),
    .push_full  (push_full),
    .pop_valid  (pop_valid),
    .pop_data   (pop_data),
    .pop        (pop)
  );

  // back: conversion and character output with the running count
  itaf_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .pop_valid       (pop_valid),
    .pop_data        (pop_data),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_char        (out_char),
    .out_last        (out_last),
    .out_total_count (out_total_count)
  );

endmodule
`default_nettype wire

// ===== tb/tb_integer_to_ascii_formatter.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_integer_to_ascii_formatter
// self-checking testbench of the integer-to-ascii formatter
// ---------------------------------------------------------------------------
// Request words are driven on the falling edge and the block is sampled on
// the rising edge. Each accepted request is turned into its expected text by
// a local model of the formatter, one entry per character, with the running
// character count. A checker takes every accepted character word and
// compares it with the oldest pending entry. Both channels idle at random.
// One phase holds the character channel off for a long stretch so that the
// request side fills up and stalls.
// ---------------------------------------------------------------------------
module tb_integer_to_ascii_formatter import itaf_pkg::*;;

  // ascii used by the local text model
  localparam logic [7:0] ASC_ZERO  = "0";
  localparam logic [7:0] ASC_MINUS = "-";
  localparam logic [7:0] ASC_UA    = "A";
  localparam logic [7:0] ASC_LA    = "a";

  localparam int HALF_PERIOD   = 4;
  localparam int RESET_CYCLES  = 7;
  localparam int RANDOM_WORDS  = 200;
  localparam int TAIL_CYCLES   = 40;
  localparam int HOLD_CYCLES   = 200;

  // one expected character word
  typedef struct {
    logic [CHAR_W-1:0]  ch;
    logic               last;
    logic [COUNT_W-1:0] count;
  } char_word_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [1:0]         in_req_type = '0;
  logic               in_upper_case = 1'b0;
  logic [VALUE_W-1:0] in_value = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [CHAR_W-1:0]  out_char;
  logic               out_last;
  logic [COUNT_W-1:0] out_total_count;

  char_word_t         expected_chars[$];
  logic [COUNT_W-1:0] char_total = '0;
  int                 fail_count = 0;

  // idling controls, set by the test tasks
  bit tx_idle_en = 1'b0;
  bit rx_idle_en = 1'b0;
  int hold_req = 0;
  int hold_left = 0;
  int rx_wait = 0;

  integer_to_ascii_formatter dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_req_type     (in_req_type),
    .in_upper_case   (in_upper_case),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_char        (out_char),
    .out_last        (out_last),
    .out_total_count (out_total_count)
  );

  always begin
    #HALF_PERIOD clk = 1'b1;
    #HALF_PERIOD clk = 1'b0;
  end

  // mostly no gap, sometimes a short one, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) begin
      pick_gap = 0;
    end else if (r < 92) begin
      pick_gap = $urandom_range(1, 3);
    end else begin
      pick_gap = $urandom_range(8, 30);
    end
  endfunction

  // builds the text of one request and queues its character words
  function automatic void predict_text(req_type_t rt, logic up, logic [VALUE_W-1:0] v);
    logic [VALUE_W-1:0] mag;
    logic [7:0]         text[$];
    logic [3:0]         d;
    logic               hex;
    char_word_t         w;
    hex = (rt == REQ_HEX32) || (rt == REQ_HEX64);
    case (rt)
      REQ_SDEC32: begin
        mag = {32'd0, v[31:0]};
        // the most negative value negates to itself, which is the right magnitude
        if (v[31]) begin
          mag = {32'd0, (~v[31:0]) + 32'd1};
        end
      end
      REQ_HEX64: begin
        mag = v;
      end
      default: begin
        // high half is ignored in the 32-bit formats
        mag = {32'd0, v[31:0]};
      end
    endcase
    // digits least significant first, pushed to the front; zero gives one '0'
    do begin
      d = hex ? mag[3:0] : 4'(mag % 10);
      if (d < 4'd10) begin
        text.push_front(ASC_ZERO + 8'(d));
      end else begin
        text.push_front((up ? ASC_UA : ASC_LA) + 8'(d) - 8'd10);
      end
      mag = hex ? (mag >> 4) : (mag / 10);
    end while (mag != 0);
    if (rt == REQ_SDEC32 && v[31]) begin
      text.push_front(ASC_MINUS);
    end
    foreach (text[i]) begin
      char_total = char_total + 1'b1;
      w.ch = text[i];
      w.last = (i == text.size() - 1);
      w.count = char_total;
      expected_chars.push_back(w);
    end
  endfunction

  // offers one request word and holds it until it is taken
  task automatic send_request(req_type_t rt, logic up, logic [VALUE_W-1:0] v);
    int gap;
    gap = tx_idle_en ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_req_type   <= rt;
    in_upper_case <= up;
    in_value      <= v;
    do @(posedge clk); while (in_stall);
    predict_text(rt, up, v);
    @(negedge clk);
  endtask

  // value shapes that reach boundaries as well as full random bits
  function automatic logic [VALUE_W-1:0] rand_value();
    logic [VALUE_W-1:0] v;
    case ($urandom_range(0, 5))
      0: v = {$urandom, $urandom};
      1: v = 64'($urandom_range(0, 20));
      2: v = 64'd1 << $urandom_range(0, 63);
      3: v = (64'd1 << $urandom_range(1, 63)) - 64'd1;
      4: v = ~64'($urandom_range(0, 20));
      default: v = {$urandom, 32'($urandom_range(0, 9999))};
    endcase
    rand_value = v;
  endfunction

  // character channel: random stall, plus the long hold when asked
  always @(negedge clk) begin
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_stall <= 1'b1;
    end else if (rx_wait > 0) begin
      rx_wait = rx_wait - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
      if (rx_idle_en) begin
        rx_wait = pick_gap();
      end
    end
  end

  // checker: every accepted character word against the oldest expectation
  always @(posedge clk) begin
    char_word_t w;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_chars.size() == 0) begin
        $error("unexpected character word: char %h last %b count %0d",
               out_char, out_last, out_total_count);
        fail_count++;
      end else begin
        w = expected_chars.pop_front();
        if (out_char !== w.ch) begin
          $error("out_char mismatch: expected %h, actual %h", w.ch, out_char);
          fail_count++;
        end
        if (out_last !== w.last) begin
          $error("out_last mismatch: expected %b, actual %b", w.last, out_last);
          fail_count++;
        end
        if (out_total_count !== w.count) begin
          $error("out_total_count mismatch: expected %0d, actual %0d",
                 w.count, out_total_count);
          fail_count++;
        end
      end
    end
  end

  // extremes, every format, both letter cases and the special values
  task automatic test_directed();
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    // zero in every format
    send_request(REQ_SDEC32, 1'b0, 64'd0);
    send_request(REQ_UDEC32, 1'b1, 64'd0);
    send_request(REQ_HEX32,  1'b0, 64'd0);
    send_request(REQ_HEX64,  1'b1, 64'd0);
    // signed limits, minus one and the most negative value
    send_request(REQ_SDEC32, 1'b0, 64'h0000_0000_7fff_ffff);
    send_request(REQ_SDEC32, 1'b0, 64'h0000_0000_8000_0000);
    send_request(REQ_SDEC32, 1'b1, 64'hffff_ffff_ffff_ffff);
    send_request(REQ_SDEC32, 1'b0, 64'd1);
    // unsigned maximum, upper case has no effect in decimal
    send_request(REQ_UDEC32, 1'b0, 64'h0000_0000_ffff_ffff);
    send_request(REQ_UDEC32, 1'b1, 64'h0000_0000_ffff_ffff);
    // high half must be ignored in the 32-bit formats
    send_request(REQ_SDEC32, 1'b0, 64'hdead_beef_0000_0000);
    send_request(REQ_UDEC32, 1'b0, 64'hffff_ffff_0000_0009);
    send_request(REQ_HEX32,  1'b1, 64'hffff_ffff_0000_00ab);
    // hex letters in both cases
    send_request(REQ_HEX32,  1'b0, 64'h0000_0000_ffff_ffff);
    send_request(REQ_HEX32,  1'b1, 64'h0000_0000_ffff_ffff);
    send_request(REQ_HEX32,  1'b0, 64'h0000_0000_abcd_ef01);
    send_request(REQ_HEX32,  1'b1, 64'h0000_0000_abcd_ef01);
    // 64-bit hex, longest text and edges
    send_request(REQ_HEX64,  1'b0, 64'hffff_ffff_ffff_ffff);
    send_request(REQ_HEX64,  1'b1, 64'hffff_ffff_ffff_ffff);
    send_request(REQ_HEX64,  1'b0, 64'h8000_0000_0000_0000);
    send_request(REQ_HEX64,  1'b0, 64'h0123_4567_89ab_cdef);
    send_request(REQ_HEX64,  1'b1, 64'hfedc_ba98_7654_3210);
    send_request(REQ_HEX64,  1'b1, 64'd1);
  endtask

  // receiver holds off while requests keep coming, so the queue fills
  task automatic test_backpressure();
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    hold_req = HOLD_CYCLES;
    repeat (10) begin
      send_request(req_type_t'($urandom_range(0, 3)), 1'($urandom), rand_value());
    end
  endtask

  // random formats and values, idling switched off for some stretches
  task automatic test_random();
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      tx_idle_en = ((i / 40) % 3) != 1;
      rx_idle_en = ((i / 40) % 3) != 1;
      send_request(req_type_t'($urandom_range(0, 3)), 1'($urandom), rand_value());
    end
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_directed();
    test_backpressure();
    test_random();

    in_valid <= 1'b0;
    rx_idle_en = 1'b1;
    // wait for every pending character, then keep watching for strays
    while (expected_chars.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);

    if (fail_count == 0 && expected_chars.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // run limit, several times the slowest correct run
  initial begin
    #8_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/itaf_pkg.sv
rtl/itaf_front.sv
rtl/itaf_queue.sv
rtl/itaf_back.sv
rtl/integer_to_ascii_formatter.sv
tb/tb_integer_to_ascii_formatter.sv
